/* sv/positional_list_engine_unit_assert.svh */
// assertion macros used by the list engine top level
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// condition must hold in the same cycle
`define PLE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// condition must hold in the next cycle
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

/* sv/ple_pkg.sv */
// shared constants, codes and types of the list engine
package ple_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // command codes
    localparam logic [3:0] F_INS_FRONT = 4'd0;
    localparam logic [3:0] F_INS_BACK  = 4'd1;
    localparam logic [3:0] F_INS_AT    = 4'd2;
    localparam logic [3:0] F_DEL_FRONT = 4'd3;
    localparam logic [3:0] F_DEL_BACK  = 4'd4;
    localparam logic [3:0] F_DEL_VALUE = 4'd5;
    localparam logic [3:0] F_DEL_AT    = 4'd6;
    localparam logic [3:0] F_SEARCH    = 4'd7;
    localparam logic [3:0] F_LIST      = 4'd8;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    // cell operations
    localparam logic [2:0] C_HOLD  = 3'd0;
    localparam logic [2:0] C_NEW   = 3'd1;
    localparam logic [2:0] C_LEFT  = 3'd2;
    localparam logic [2:0] C_RIGHT = 3'd3;
    localparam logic [2:0] C_FRONT = 3'd4;

    typedef logic [DATA_W-1:0] t_word;

    typedef struct packed {
        logic [2:0] op;
    } t_cell_ctl;

endpackage

/* sv/ple_cell.sv */
// one list position: holds or loads an entry, shifts from a neighbor or cell 0, compares a key
module ple_cell import ple_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_word     i_left,
    input  t_word     i_right,
    input  t_word     i_front,
    input  t_word     i_new,
    input  t_word     i_key,
    output t_word     o_data,
    output logic      o_match
);

    t_word r_data;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            C_HOLD:  r_data <= r_data;
            C_NEW:   r_data <= i_new;
            C_LEFT:  r_data <= i_left;
            C_RIGHT: r_data <= i_right;
            C_FRONT: r_data <= i_front;
            default: r_data <= r_data;
        endcase
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

/* sv/positional_list_engine_unit.sv */
// top level of the list engine: command control, cell row and result register
//
// Input channel: i_in_valid / o_in_stall carry one command word (i_func,
// i_item_value, i_item_index). Output channel: o_out_valid / i_out_stall carry
// result words. A word moves at a clock edge with valid high and stall low.
// The list lives in a row of DEPTH cells; inserts and deletes shift the
// cells from the target position on at once, and every cell compares its entry with
// the command value as the command is taken.
// The take cycle latches the compare results; in the EXEC state, once the
// result register may load, the engine decides status, shifts the cells and
// loads the result register. A listing then emits one word a cycle while
// the receiver does not stall, by rotating the row through cell 0, and the
// row ends in its original order.
// o_in_stall is high while a command is in flight. When the receiver stalls,
// the result register holds its word and the engine waits before loading
// the next one; no word is dropped.
// Reset (synchronous, active low) empties the list and clears output valid;
// entry storage is not cleared, as only occupied positions are ever read.
module positional_list_engine_unit import ple_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [3:0]               i_func,
    input  logic signed [DATA_W-1:0] i_item_value,
    input  logic [IDX_W-1:0]         i_item_index,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [2:0]               o_status,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic [IDX_W-1:0]         o_out_index,
    output logic [IDX_W-1:0]         o_entry_count,
    output logic                     o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic [3:0]       r_func;
    t_word            r_value;
    logic [IDX_W-1:0] r_idx;
    logic [DEPTH-1:0] r_match;

    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_status, n_status;
    t_word            r_out_value, n_out_value;
    logic [IDX_W-1:0] r_out_index, n_out_index;
    logic [IDX_W-1:0] r_count, n_count;
    logic             r_last, n_last;

    t_word            cell_data [DEPTH];
    logic [DEPTH-1:0] cell_match;
    t_cell_ctl        cell_ctl [DEPTH];

    logic             accept, out_load;
    logic             is_full, is_empty, found;
    logic [CMP_W-1:0] occ_w, idx_w, fpos, pos;
    logic             do_ins, do_del, do_rot;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_load = !r_out_valid || !i_out_stall;
    assign occ_w    = CMP_W'(r_occ);
    assign idx_w    = CMP_W'(r_idx);
    assign is_full  = (r_occ == CNT_W'(DEPTH));
    assign is_empty = (r_occ == '0);

    // first matching occupied position
    always_comb begin
        found = 1'b0;
        fpos  = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (r_match[i] && (CMP_W'(i) < occ_w)) begin
                found = 1'b1;
                fpos  = CMP_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_out_value = r_out_value;
        n_out_index = r_out_index;
        n_count     = r_count;
        n_last      = r_last;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        do_rot      = 1'b0;
        pos         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_out_value = '0;
                    n_out_index = '0;
                    n_last      = 1'b1;
                    unique case (r_func)
                        F_INS_FRONT, F_INS_BACK, F_INS_AT: begin
                            if (r_func == F_INS_FRONT) begin
                                pos = '0;
                            end else if (r_func == F_INS_BACK) begin
                                pos = occ_w;
                            end else begin
                                pos = idx_w;
                            end
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else if (pos > occ_w) begin
                                n_status = ST_RANGE;
                            end else begin
                                do_ins = 1'b1;
                                n_occ  = r_occ + 1'b1;
                            end
                        end
                        F_DEL_FRONT, F_DEL_BACK, F_DEL_VALUE, F_DEL_AT: begin
                            if (r_func == F_DEL_FRONT) begin
                                pos = '0;
                            end else if (r_func == F_DEL_BACK) begin
                                pos = occ_w - 1'b1;
                            end else if (r_func == F_DEL_VALUE) begin
                                pos = fpos;
                            end else begin
                                pos = idx_w;
                            end
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else if ((r_func == F_DEL_VALUE) && !found) begin
                                n_status = ST_NOTFOUND;
                            end else if (pos >= occ_w) begin
                                n_status = ST_RANGE;
                            end else begin
                                do_del = 1'b1;
                                n_occ  = r_occ - 1'b1;
                            end
                        end
                        F_SEARCH: begin
                            if (found) begin
                                n_out_index = IDX_W'(fpos);
                            end else begin
                                n_status = ST_NOTFOUND;
                            end
                        end
                        F_LIST: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // first listed word goes out from the list state
                                n_out_valid = r_out_valid && i_out_stall;
                                n_state     = S_LIST;
                                n_ptr       = '0;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                    n_count = IDX_W'(n_occ);
                end
            end
            S_LIST: begin
                if (out_load) begin
                    do_rot      = 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_out_value = cell_data[0];
                    n_out_index = IDX_W'(r_ptr);
                    n_count     = IDX_W'(r_occ);
                    n_last      = (CNT_W'(r_ptr + 1'b1) == r_occ);
                    if (n_last) begin
                        n_state = S_IDLE;
                        n_ptr   = '0;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // per-cell shift control
    always_comb begin
        logic [CMP_W-1:0] iw;
        for (int i = 0; i < DEPTH; i++) begin
            iw            = CMP_W'(i);
            cell_ctl[i].op = C_HOLD;
            if (do_ins) begin
                if (iw == pos) begin
                    cell_ctl[i].op = C_NEW;
                end else if ((iw > pos) && (iw <= occ_w)) begin
                    cell_ctl[i].op = C_LEFT;
                end
            end else if (do_del) begin
                if ((iw >= pos) && (iw + 1'b1 < occ_w)) begin
                    cell_ctl[i].op = C_RIGHT;
                end
            end else if (do_rot) begin
                if (iw + 1'b1 < occ_w) begin
                    cell_ctl[i].op = C_RIGHT;
                end else if (iw + 1'b1 == occ_w) begin
                    cell_ctl[i].op = C_FRONT;
                end
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word left_w, right_w;
        if (g == 0) begin : g_first
            assign left_w = r_value;
        end else begin : g_mid_l
            assign left_w = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign right_w = cell_data[g];
        end else begin : g_mid_r
            assign right_w = cell_data[g+1];
        end
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_left  (left_w),
            .i_right (right_w),
            .i_front (cell_data[0]),
            .i_new   (r_value),
            .i_key   (t_word'(i_item_value)),
            .o_data  (cell_data[g]),
            .o_match (cell_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_value <= t_word'(i_item_value);
            r_idx   <= i_item_index;
            r_match <= cell_match;
        end
        r_status    <= n_status;
        r_out_value <= n_out_value;
        r_out_index <= n_out_index;
        r_count     <= n_count;
        r_last      <= n_last;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_value   = r_out_value;
    assign o_out_index   = r_out_index;
    assign o_entry_count = r_count;
    assign o_last        = r_last;

`include "positional_list_engine_unit_assert.svh"

    `PLE_ASSERT_NOW(a_occ_bound, 1'b1, r_occ <= CNT_W'(DEPTH))
    `PLE_ASSERT_NOW(a_ptr_bound, r_state == S_LIST, r_ptr < r_occ)
    `PLE_ASSERT_NEXT(a_list_keeps_occ, r_state == S_LIST, $stable(r_occ))
    `PLE_ASSERT_NEXT(a_exec_step, r_state == S_EXEC, (r_occ + 1'b1 - $past(r_occ)) <= CNT_W'(2))

endmodule
